// ===== rtl/rlt_component_tlv_parser_core_macros.svh =====
// Assertion macros used by the port-level checker of the component parser.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef RLT_COMPONENT_TLV_PARSER_CORE_MACROS_SVH
`define RLT_COMPONENT_TLV_PARSER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RLT_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RLT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Delayed implication: the consequent is checked after the antecedent.
`define RLT_ASSERT_TWO(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##2 (cons)) \
		else $error(msg);

`endif

// ===== rtl/rlt_tlv_pkg.sv =====
// Package of the component tag-length-value parser: tags, lengths, parse phases and codes.
// Used by the top level and the testbench; depends on nothing.
package rlt_tlv_pkg;

	localparam logic [7:0] TAG_SEQ = 8'h30;
	localparam logic [7:0] TAG_OP  = 8'h02;
	localparam logic [7:0] TAG_CID = 8'h80;
	localparam logic [7:0] TAG_RSN = 8'h81;

	localparam logic [7:0] SEQ_LEN        = 8'h09;
	localparam logic [7:0] OP_LEN         = 8'h01;
	localparam logic [7:0] RSN_LEN        = 8'h01;
	localparam logic [7:0] OP_VAL_LENIENT = 8'h02;
	localparam logic [7:0] CID_LEN_FOUR   = 8'h04;
	localparam logic [7:0] CID_LEN_THREE  = 8'h03;

	localparam logic [7:0] EXP_OP_RESET = 8'h01;

	localparam logic [1:0] KIND_STRICT  = 2'd1;
	localparam logic [1:0] KIND_LENIENT = 2'd2;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_SEQ_STOP = 3'd1;
	localparam logic [2:0] ST_OP_LEN   = 3'd2;
	localparam logic [2:0] ST_OP_VAL   = 3'd3;
	localparam logic [2:0] ST_BAD_TAG  = 3'd4;
	localparam logic [2:0] ST_TRUNC    = 3'd5;

	localparam int FLAG_CID = 0;
	localparam int FLAG_RSN = 1;
	localparam int FLAG_MIS = 2;

	typedef enum logic [2:0] {
		PH_TAG,
		PH_SEQ_LEN,
		PH_OP_LEN,
		PH_OP_VAL,
		PH_CID_LEN,
		PH_CID_VAL,
		PH_RSN_LEN,
		PH_RSN_VAL
	} phase_t;

endpackage

// ===== rtl/rlt_tlv_byte_if.sv =====
// Channel that carries one component byte per word with its message marks.
// Depends on nothing.
interface rlt_tlv_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       first_byte;
	logic       last_byte;
	logic [1:0] msg_kind;

	modport source (output valid, data_byte, first_byte, last_byte, msg_kind, input ready);
	modport sink (input valid, data_byte, first_byte, last_byte, msg_kind, output ready);
endinterface

// ===== rtl/rlt_tlv_result_if.sv =====
// Channel that carries one parse result per word.
// Depends on nothing.
interface rlt_tlv_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [31:0] call_id;
	logic [7:0]  call_id_length;
	logic        call_id_seen;
	logic [7:0]  redirect_reason;
	logic        reason_seen;
	logic        mismatch_seen;

	modport source (output valid, status, call_id, call_id_length, call_id_seen,
		redirect_reason, reason_seen, mismatch_seen, input ready);
	modport sink (input valid, status, call_id, call_id_length, call_id_seen,
		redirect_reason, reason_seen, mismatch_seen, output ready);
endinterface

// ===== rtl/rlt_component_tlv_parser_core.sv =====
// Top level of the component tag-length-value parser.
// Depends on rlt_tlv_pkg, rlt_tlv_byte_if and rlt_tlv_result_if.
//
//   Channel   Direction  Word
//   comp      sink       one component byte with first, last and kind marks
//   res       source     one parse result after each byte marked last
//   cfg_*     write      expected operation value for strict parsing
//
// A byte is registered on acceptance and parsed from the byte register, so one byte
// is taken every cycle unless the byte register stalls. The result of a last byte is
// registered in the result register when that byte leaves the byte register.
// The byte register stalls only when it holds a last byte and the result register
// is still full; a byte that is not last never waits on the result side.
// Reset clears all parse state and sets the expected operation value to one.
module rlt_component_tlv_parser_core (
	input  logic                  clk,
	input  logic                  arst_n,
	rlt_tlv_byte_if.sink          comp,
	rlt_tlv_result_if.source      res,
	input  logic                  cfg_we,
	input  logic [7:0]            cfg_wdata
);

	logic [7:0] exp_op_q;

	logic       valid_s1;
	logic [7:0] data_s1;
	logic       first_s1;
	logic       last_s1;
	logic [1:0] kind_s1;
	logic       go_s1;
	logic       fire_s1;

	rlt_tlv_pkg::phase_t phase_q, phase_b, phase_n;
	logic [2:0]  left_q, left_b, left_n;
	logic [31:0] acc_q, acc_b, acc_n;
	logic [7:0]  cid_len_q, cid_len_b, cid_len_n;
	logic [7:0]  rsn_q, rsn_b, rsn_n;
	logic [2:0]  flags_q, flags_b, flags_n;
	logic [2:0]  status_q, status_b, status_n;
	logic        halted_q, halted_b, halted_n;

	logic        strict;
	logic        parse_en;
	logic [1:0]  byte_pos;
	logic [31:0] byte_shifted;

	logic        res_valid_q;
	logic [2:0]  res_status_q;
	logic [31:0] res_call_id_q;
	logic [7:0]  res_cid_len_q;
	logic        res_cid_seen_q;
	logic [7:0]  res_rsn_q;
	logic        res_rsn_seen_q;
	logic        res_mis_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_op_q <= rlt_tlv_pkg::EXP_OP_RESET;
		end else if (cfg_we) begin
			exp_op_q <= cfg_wdata;
		end
	end

	assign go_s1      = !last_s1 || !res_valid_q || res.ready;
	assign fire_s1    = valid_s1 && go_s1;
	assign comp.ready = !valid_s1 || go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (comp.ready) begin
			valid_s1 <= comp.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (comp.ready && comp.valid) begin
			data_s1  <= comp.data_byte;
			first_s1 <= comp.first_byte;
			last_s1  <= comp.last_byte;
			kind_s1  <= comp.msg_kind;
		end
	end

	assign strict       = (kind_s1 == rlt_tlv_pkg::KIND_STRICT);
	assign byte_pos     = left_b[1:0] - 2'd1;
	assign byte_shifted = {24'd0, data_s1} << {byte_pos, 3'b000};

	always_comb begin
		if (first_s1) begin
			phase_b   = rlt_tlv_pkg::PH_TAG;
			left_b    = 3'd0;
			acc_b     = 32'd0;
			cid_len_b = 8'd0;
			rsn_b     = 8'd0;
			flags_b   = 3'd0;
			status_b  = rlt_tlv_pkg::ST_OK;
			halted_b  = 1'b0;
		end else begin
			phase_b   = phase_q;
			left_b    = left_q;
			acc_b     = acc_q;
			cid_len_b = cid_len_q;
			rsn_b     = rsn_q;
			flags_b   = flags_q;
			status_b  = status_q;
			halted_b  = halted_q;
		end

		phase_n   = phase_b;
		left_n    = left_b;
		acc_n     = acc_b;
		cid_len_n = cid_len_b;
		rsn_n     = rsn_b;
		flags_n   = flags_b;
		status_n  = status_b;
		halted_n  = halted_b;

		parse_en = !halted_b && (kind_s1 == rlt_tlv_pkg::KIND_STRICT ||
			kind_s1 == rlt_tlv_pkg::KIND_LENIENT);

		if (parse_en) begin
			case (phase_b)
				rlt_tlv_pkg::PH_SEQ_LEN: begin
					phase_n = rlt_tlv_pkg::PH_TAG;
					if (data_s1 != rlt_tlv_pkg::SEQ_LEN) begin
						if (strict) begin
							status_n = rlt_tlv_pkg::ST_SEQ_STOP;
							halted_n = 1'b1;
						end else begin
							flags_n[rlt_tlv_pkg::FLAG_MIS] = 1'b1;
						end
					end
				end
				rlt_tlv_pkg::PH_OP_LEN: begin
					phase_n = rlt_tlv_pkg::PH_OP_VAL;
					if (data_s1 != rlt_tlv_pkg::OP_LEN) begin
						if (strict) begin
							status_n = rlt_tlv_pkg::ST_OP_LEN;
							halted_n = 1'b1;
							phase_n  = rlt_tlv_pkg::PH_TAG;
						end else begin
							flags_n[rlt_tlv_pkg::FLAG_MIS] = 1'b1;
						end
					end
				end
				rlt_tlv_pkg::PH_OP_VAL: begin
					phase_n = rlt_tlv_pkg::PH_TAG;
					if (strict) begin
						if (data_s1 != exp_op_q) begin
							status_n = rlt_tlv_pkg::ST_OP_VAL;
							halted_n = 1'b1;
						end
					end else if (data_s1 != rlt_tlv_pkg::OP_VAL_LENIENT) begin
						flags_n[rlt_tlv_pkg::FLAG_MIS] = 1'b1;
					end
				end
				rlt_tlv_pkg::PH_CID_LEN: begin
					cid_len_n = data_s1;
					if (data_s1 inside {rlt_tlv_pkg::CID_LEN_FOUR,
							rlt_tlv_pkg::CID_LEN_THREE}) begin
						left_n  = data_s1[2:0];
						phase_n = rlt_tlv_pkg::PH_CID_VAL;
					end else begin
						phase_n = rlt_tlv_pkg::PH_TAG;
					end
				end
				rlt_tlv_pkg::PH_CID_VAL: begin
					if (left_b inside {[3'd1:3'd4]}) begin
						acc_n  = acc_b | byte_shifted;
						left_n = left_b - 3'd1;
					end else begin
						left_n = 3'd0;
					end
					if (left_n == 3'd0) begin
						phase_n = rlt_tlv_pkg::PH_TAG;
					end
				end
				rlt_tlv_pkg::PH_RSN_LEN: begin
					phase_n = rlt_tlv_pkg::PH_RSN_VAL;
					if (data_s1 != rlt_tlv_pkg::RSN_LEN) begin
						flags_n[rlt_tlv_pkg::FLAG_MIS] = 1'b1;
					end
				end
				rlt_tlv_pkg::PH_RSN_VAL: begin
					rsn_n   = data_s1;
					phase_n = rlt_tlv_pkg::PH_TAG;
				end
				default: begin
					if (data_s1 == rlt_tlv_pkg::TAG_SEQ) begin
						phase_n = rlt_tlv_pkg::PH_SEQ_LEN;
					end else if (data_s1 == rlt_tlv_pkg::TAG_OP) begin
						phase_n = rlt_tlv_pkg::PH_OP_LEN;
					end else if (data_s1 == rlt_tlv_pkg::TAG_CID) begin
						flags_n[rlt_tlv_pkg::FLAG_CID] = 1'b1;
						phase_n = rlt_tlv_pkg::PH_CID_LEN;
					end else if (data_s1 == rlt_tlv_pkg::TAG_RSN && !strict) begin
						flags_n[rlt_tlv_pkg::FLAG_RSN] = 1'b1;
						phase_n = rlt_tlv_pkg::PH_RSN_LEN;
					end else begin
						status_n = rlt_tlv_pkg::ST_BAD_TAG;
						halted_n = 1'b1;
						phase_n  = rlt_tlv_pkg::PH_TAG;
					end
				end
			endcase
		end

		if (last_s1 && !halted_n && phase_n != rlt_tlv_pkg::PH_TAG) begin
			status_n = rlt_tlv_pkg::ST_TRUNC;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= rlt_tlv_pkg::PH_TAG;
			left_q    <= 3'd0;
			acc_q     <= 32'd0;
			cid_len_q <= 8'd0;
			rsn_q     <= 8'd0;
			flags_q   <= 3'd0;
			status_q  <= rlt_tlv_pkg::ST_OK;
			halted_q  <= 1'b0;
		end else if (fire_s1) begin
			phase_q   <= phase_n;
			left_q    <= left_n;
			acc_q     <= acc_n;
			cid_len_q <= cid_len_n;
			rsn_q     <= rsn_n;
			flags_q   <= flags_n;
			status_q  <= status_n;
			halted_q  <= halted_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fire_s1 && last_s1) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && last_s1) begin
			res_status_q   <= status_n;
			res_call_id_q  <= acc_n;
			res_cid_len_q  <= cid_len_n;
			res_cid_seen_q <= flags_n[rlt_tlv_pkg::FLAG_CID];
			res_rsn_q      <= rsn_n;
			res_rsn_seen_q <= flags_n[rlt_tlv_pkg::FLAG_RSN];
			res_mis_q      <= flags_n[rlt_tlv_pkg::FLAG_MIS];
		end
	end

	assign res.valid           = res_valid_q;
	assign res.status          = res_status_q;
	assign res.call_id         = res_call_id_q;
	assign res.call_id_length  = res_cid_len_q;
	assign res.call_id_seen    = res_cid_seen_q;
	assign res.redirect_reason = res_rsn_q;
	assign res.reason_seen     = res_rsn_seen_q;
	assign res.mismatch_seen   = res_mis_q;

endmodule

// ===== rtl/rlt_tlv_chk.sv =====
// Port-level checker for the component parser, bound to its top level.
// Depends on rlt_component_tlv_parser_core_macros.svh and the top level's ports.
`include "rlt_component_tlv_parser_core_macros.svh"

module rlt_tlv_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        comp_valid,
	input logic        comp_ready,
	input logic        comp_last,
	input logic        res_valid,
	input logic        res_ready,
	input logic [2:0]  res_status,
	input logic [31:0] res_call_id,
	input logic [7:0]  res_call_id_length,
	input logic        res_call_id_seen,
	input logic [7:0]  res_redirect_reason,
	input logic        res_reason_seen
);

	logic        last_acc;
	logic        res_stall;
	logic [52:0] res_word;
	logic        cid_clear;
	logic        rsn_clear;

	assign last_acc  = comp_valid && comp_ready && comp_last;
	assign res_stall = res_valid && !res_ready;
	assign res_word  = {res_status, res_call_id, res_call_id_length, res_call_id_seen,
		res_redirect_reason, res_reason_seen};
	assign cid_clear = (res_call_id == 32'd0) && (res_call_id_length == 8'd0);
	assign rsn_clear = (res_redirect_reason == 8'd0);

	`RLT_ASSERT_TWO(a_last_res, last_acc, res_valid, "accepted last word gave no result")
	`RLT_ASSERT_NEXT(a_res_hold, res_stall, res_valid && $stable(res_word), "stalled word changed")
	`RLT_ASSERT_SAME(a_cid_empty, res_valid && !res_call_id_seen, cid_clear, "stray call id")
	`RLT_ASSERT_SAME(a_rsn_empty, res_valid && !res_reason_seen, rsn_clear, "stray reason")

endmodule

bind rlt_component_tlv_parser_core rlt_tlv_chk u_chk (
	.clk                 (clk),
	.arst_n              (arst_n),
	.comp_valid          (comp.valid),
	.comp_ready          (comp.ready),
	.comp_last           (comp.last_byte),
	.res_valid           (res.valid),
	.res_ready           (res.ready),
	.res_status          (res.status),
	.res_call_id         (res.call_id),
	.res_call_id_length  (res.call_id_length),
	.res_call_id_seen    (res.call_id_seen),
	.res_redirect_reason (res.redirect_reason),
	.res_reason_seen     (res.reason_seen)
);

// ===== test/testbench.sv =====
// Self-checking testbench of the component tag-length-value parser core.
// Depends on rlt_tlv_pkg, rlt_tlv_byte_if, rlt_tlv_result_if and rlt_component_tlv_parser_core.
// A small scoreboard class tracks the parse state of each accepted word and checks every result.
module testbench;

	localparam logic [1:0] KIND_NONE_LOW  = 2'd0;
	localparam logic [1:0] KIND_NONE_HIGH = 2'd3;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 400;
	localparam int PHASE_ITEMS = 335;

	typedef struct {
		logic [7:0] data;
		logic       first;
		logic       last;
		logic [1:0] kind;
	} comp_word_t;

	typedef struct {
		logic [2:0]  status;
		logic [31:0] call_id;
		logic [7:0]  call_id_length;
		logic        call_id_seen;
		logic [7:0]  redirect_reason;
		logic        reason_seen;
		logic        mismatch_seen;
	} parse_result_t;

	class tlv_result_book;
		bit [7:0]            exp_op;
		rlt_tlv_pkg::phase_t phase;
		bit [2:0]            left;
		bit [31:0]           cid;
		bit [7:0]            cid_len;
		bit [7:0]            rsn;
		bit [2:0]            flags;
		bit [2:0]            status;
		bit                  halted;
		parse_result_t       pending_results[$];
		int                  errors;
		int                  bytes_taken;
		int                  results_checked;

		function new();
			exp_op = rlt_tlv_pkg::EXP_OP_RESET;
			errors = 0;
			bytes_taken = 0;
			results_checked = 0;
			clear();
		endfunction

		function void clear();
			phase = rlt_tlv_pkg::PH_TAG;
			left = 3'd0;
			cid = 32'd0;
			cid_len = 8'd0;
			rsn = 8'd0;
			flags = 3'd0;
			status = rlt_tlv_pkg::ST_OK;
			halted = 1'b0;
		endfunction

		function void halt(bit [2:0] code);
			status = code;
			halted = 1'b1;
			phase = rlt_tlv_pkg::PH_TAG;
		endfunction

		function void parse_one_byte(bit [7:0] b, bit strict);
			int sh;
			case (phase)
				rlt_tlv_pkg::PH_SEQ_LEN: begin
					phase = rlt_tlv_pkg::PH_TAG;
					if (b != rlt_tlv_pkg::SEQ_LEN) begin
						if (strict) halt(rlt_tlv_pkg::ST_SEQ_STOP);
						else flags[rlt_tlv_pkg::FLAG_MIS] = 1'b1;
					end
				end
				rlt_tlv_pkg::PH_OP_LEN: begin
					phase = rlt_tlv_pkg::PH_OP_VAL;
					if (b != rlt_tlv_pkg::OP_LEN) begin
						if (strict) halt(rlt_tlv_pkg::ST_OP_LEN);
						else flags[rlt_tlv_pkg::FLAG_MIS] = 1'b1;
					end
				end
				rlt_tlv_pkg::PH_OP_VAL: begin
					phase = rlt_tlv_pkg::PH_TAG;
					if (strict) begin
						if (b != exp_op) halt(rlt_tlv_pkg::ST_OP_VAL);
					end else if (b != rlt_tlv_pkg::OP_VAL_LENIENT) begin
						flags[rlt_tlv_pkg::FLAG_MIS] = 1'b1;
					end
				end
				rlt_tlv_pkg::PH_CID_LEN: begin
					cid_len = b;
					if (b == rlt_tlv_pkg::CID_LEN_FOUR || b == rlt_tlv_pkg::CID_LEN_THREE) begin
						left = b[2:0];
						phase = rlt_tlv_pkg::PH_CID_VAL;
					end else begin
						phase = rlt_tlv_pkg::PH_TAG;
					end
				end
				rlt_tlv_pkg::PH_CID_VAL: begin
					if (left >= 3'd1 && left <= 3'd4) begin
						sh = 8 * (int'(left) - 1);
						cid = cid | (32'(b) << sh);
						left = left - 3'd1;
					end else begin
						left = 3'd0;
					end
					if (left == 3'd0) phase = rlt_tlv_pkg::PH_TAG;
				end
				rlt_tlv_pkg::PH_RSN_LEN: begin
					phase = rlt_tlv_pkg::PH_RSN_VAL;
					if (b != rlt_tlv_pkg::RSN_LEN) flags[rlt_tlv_pkg::FLAG_MIS] = 1'b1;
				end
				rlt_tlv_pkg::PH_RSN_VAL: begin
					rsn = b;
					phase = rlt_tlv_pkg::PH_TAG;
				end
				default: begin
					case (b)
						rlt_tlv_pkg::TAG_SEQ: phase = rlt_tlv_pkg::PH_SEQ_LEN;
						rlt_tlv_pkg::TAG_OP: phase = rlt_tlv_pkg::PH_OP_LEN;
						rlt_tlv_pkg::TAG_CID: begin
							flags[rlt_tlv_pkg::FLAG_CID] = 1'b1;
							phase = rlt_tlv_pkg::PH_CID_LEN;
						end
						rlt_tlv_pkg::TAG_RSN: begin
							if (strict) begin
								halt(rlt_tlv_pkg::ST_BAD_TAG);
							end else begin
								flags[rlt_tlv_pkg::FLAG_RSN] = 1'b1;
								phase = rlt_tlv_pkg::PH_RSN_LEN;
							end
						end
						default: halt(rlt_tlv_pkg::ST_BAD_TAG);
					endcase
				end
			endcase
		endfunction

		function void take_byte(comp_word_t w);
			parse_result_t r;
			bytes_taken++;
			if (w.first) clear();
			if (!halted && (w.kind == rlt_tlv_pkg::KIND_STRICT ||
					w.kind == rlt_tlv_pkg::KIND_LENIENT))
				parse_one_byte(w.data, w.kind == rlt_tlv_pkg::KIND_STRICT);
			if (w.last) begin
				if (!halted && phase != rlt_tlv_pkg::PH_TAG) status = rlt_tlv_pkg::ST_TRUNC;
				r.status = status;
				r.call_id = cid;
				r.call_id_length = cid_len;
				r.call_id_seen = flags[rlt_tlv_pkg::FLAG_CID];
				r.redirect_reason = rsn;
				r.reason_seen = flags[rlt_tlv_pkg::FLAG_RSN];
				r.mismatch_seen = flags[rlt_tlv_pkg::FLAG_MIS];
				pending_results.push_back(r);
			end
		endfunction

		task flag_mismatch(string what);
			errors++;
			if (errors <= 40) $display("MISMATCH at result %0d: %s", results_checked, what);
		endtask

		task match_result(parse_result_t got);
			parse_result_t want;
			results_checked++;
			if (pending_results.size() == 0) begin
				flag_mismatch("result arrived with no last byte waiting for one");
				return;
			end
			want = pending_results.pop_front();
			if (got.status !== want.status)
				flag_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
			if (got.call_id !== want.call_id)
				flag_mismatch($sformatf("call_id %h, expected %h", got.call_id, want.call_id));
			if (got.call_id_length !== want.call_id_length)
				flag_mismatch($sformatf("call_id_length %h, expected %h",
					got.call_id_length, want.call_id_length));
			if (got.call_id_seen !== want.call_id_seen)
				flag_mismatch($sformatf("call_id_seen %b, expected %b",
					got.call_id_seen, want.call_id_seen));
			if (got.redirect_reason !== want.redirect_reason)
				flag_mismatch($sformatf("redirect_reason %h, expected %h",
					got.redirect_reason, want.redirect_reason));
			if (got.reason_seen !== want.reason_seen)
				flag_mismatch($sformatf("reason_seen %b, expected %b",
					got.reason_seen, want.reason_seen));
			if (got.mismatch_seen !== want.mismatch_seen)
				flag_mismatch($sformatf("mismatch_seen %b, expected %b",
					got.mismatch_seen, want.mismatch_seen));
		endtask
	endclass

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we;
	logic [7:0] cfg_wdata;

	rlt_tlv_byte_if   comp_ch();
	rlt_tlv_result_if res_ch();

	rlt_component_tlv_parser_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.comp      (comp_ch),
		.res       (res_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	tlv_result_book book = new();
	comp_word_t     msg_buf[$];
	logic [7:0]     cur_exp_op = rlt_tlv_pkg::EXP_OP_RESET;
	int             cycles = 0;
	int             fast_left = 0;
	bit             fast_msg = 1'b0;
	bit             hold_req = 1'b0;
	int             sent_messages = 0;
	int             settings_used = 1;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
	end

	initial begin
		while (cycles < CYCLE_LIMIT) @(posedge clk);
		$display("Run stopped after %0d cycles with %0d results still outstanding.",
			cycles, book.pending_results.size());
		$display("Verification failed");
		$finish;
	end

	function automatic void put(logic [7:0] d, logic f, logic l, logic [1:0] k);
		msg_buf.push_back('{data: d, first: f, last: l, kind: k});
	endfunction

	task automatic send_word(comp_word_t w);
		int gap;
		gap = (fast_left > 0 || fast_msg) ? 0 : $urandom_range(0, 14);
		if (fast_left > 0) fast_left--;
		if (gap > 0) begin
			comp_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		comp_ch.valid <= 1'b1;
		comp_ch.data_byte <= w.data;
		comp_ch.first_byte <= w.first;
		comp_ch.last_byte <= w.last;
		comp_ch.msg_kind <= w.kind;
		do @(posedge clk); while (comp_ch.ready !== 1'b1);
		book.take_byte(w);
	endtask

	task automatic flush_words();
		while (msg_buf.size() != 0) send_word(msg_buf.pop_front());
		sent_messages++;
	endtask

	task automatic quiesce();
		comp_ch.valid <= 1'b0;
		while (book.pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_exp_op(logic [7:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		book.exp_op = v;
		cur_exp_op = v;
		settings_used++;
	endtask

	task automatic build_random_message();
		logic [7:0] body[$];
		logic [7:0] len;
		logic [1:0] kind;
		logic [1:0] k;
		bit         mixed;
		int         r;
		int         nfields;
		int         cut;
		r = $urandom_range(0, 9);
		kind = (r < 4) ? rlt_tlv_pkg::KIND_STRICT : (r < 8) ? rlt_tlv_pkg::KIND_LENIENT :
			(r == 8) ? KIND_NONE_LOW : KIND_NONE_HIGH;
		mixed = ($urandom_range(0, 9) == 0);
		fast_msg = ($urandom_range(0, 2) == 0);
		nfields = $urandom_range(1, 4);
		for (int i = 0; i < nfields; i++) begin
			r = $urandom_range(0, 9);
			if (r < 2) begin
				body.push_back(rlt_tlv_pkg::TAG_SEQ);
				body.push_back(($urandom_range(0, 4) == 0) ? 8'($urandom) :
					rlt_tlv_pkg::SEQ_LEN);
			end else if (r < 4) begin
				body.push_back(rlt_tlv_pkg::TAG_OP);
				body.push_back(($urandom_range(0, 5) == 0) ? 8'($urandom) :
					rlt_tlv_pkg::OP_LEN);
				if ($urandom_range(0, 5) == 0) body.push_back(8'($urandom));
				else if (kind == rlt_tlv_pkg::KIND_STRICT) body.push_back(cur_exp_op);
				else body.push_back(rlt_tlv_pkg::OP_VAL_LENIENT);
			end else if (r < 7) begin
				body.push_back(rlt_tlv_pkg::TAG_CID);
				if ($urandom_range(0, 5) == 0) len = 8'($urandom);
				else len = $urandom_range(0, 1) ? rlt_tlv_pkg::CID_LEN_FOUR :
					rlt_tlv_pkg::CID_LEN_THREE;
				body.push_back(len);
				if (len == rlt_tlv_pkg::CID_LEN_FOUR || len == rlt_tlv_pkg::CID_LEN_THREE) begin
					for (int j = 0; j < int'(len); j++) body.push_back(8'($urandom));
				end
			end else if (r < 9) begin
				body.push_back(rlt_tlv_pkg::TAG_RSN);
				body.push_back(($urandom_range(0, 5) == 0) ? 8'($urandom) :
					rlt_tlv_pkg::RSN_LEN);
				body.push_back(8'($urandom));
			end else begin
				body.push_back(8'($urandom));
			end
		end
		if (body.size() > 1 && $urandom_range(0, 9) == 0) begin
			cut = $urandom_range(1, body.size() - 1);
			repeat (cut) void'(body.pop_back());
		end
		foreach (body[i]) begin
			k = mixed ? 2'($urandom_range(0, 3)) : kind;
			put(body[i],
				(i == 0 && $urandom_range(0, 19) != 0) || $urandom_range(0, 63) == 0,
				(i == body.size() - 1 && $urandom_range(0, 9) != 0) ||
					$urandom_range(0, 63) == 0,
				k);
		end
	endtask

	initial begin : result_sink
		parse_result_t got;
		int            gap;
		res_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				res_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
				if (gap > 0) begin
					res_ch.ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (res_ch.valid !== 1'b1);
			got.status = res_ch.status;
			got.call_id = res_ch.call_id;
			got.call_id_length = res_ch.call_id_length;
			got.call_id_seen = res_ch.call_id_seen;
			got.redirect_reason = res_ch.redirect_reason;
			got.reason_seen = res_ch.reason_seen;
			got.mismatch_seen = res_ch.mismatch_seen;
			book.match_result(got);
		end
	end

	initial begin : byte_source
		logic [7:0] op_val;
		int         target;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= 8'h00;
		comp_ch.valid <= 1'b0;
		comp_ch.data_byte <= 8'h00;
		comp_ch.first_byte <= 1'b0;
		comp_ch.last_byte <= 1'b0;
		comp_ch.msg_kind <= KIND_NONE_LOW;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Lenient call id and reason with a wrong reason length.
		put(rlt_tlv_pkg::TAG_CID, 1'b1, 1'b0, rlt_tlv_pkg::KIND_LENIENT);
		put(rlt_tlv_pkg::CID_LEN_THREE, 1'b0, 1'b0, rlt_tlv_pkg::KIND_LENIENT);
		put(8'hFF, 1'b0, 1'b0, rlt_tlv_pkg::KIND_LENIENT);
		put(8'h00, 1'b0, 1'b0, rlt_tlv_pkg::KIND_LENIENT);
		put(8'h01, 1'b0, 1'b0, rlt_tlv_pkg::KIND_LENIENT);
		put(rlt_tlv_pkg::TAG_RSN, 1'b0, 1'b0, rlt_tlv_pkg::KIND_LENIENT);
		put(8'h02, 1'b0, 1'b0, rlt_tlv_pkg::KIND_LENIENT);
		put(8'hFF, 1'b0, 1'b1, rlt_tlv_pkg::KIND_LENIENT);
		// Strict stop on a wrong sequence length; the bytes after it are ignored.
		put(rlt_tlv_pkg::TAG_SEQ, 1'b1, 1'b0, rlt_tlv_pkg::KIND_STRICT);
		put(8'h05, 1'b0, 1'b0, rlt_tlv_pkg::KIND_STRICT);
		put(rlt_tlv_pkg::TAG_CID, 1'b0, 1'b1, rlt_tlv_pkg::KIND_STRICT);
		// Strict failures on operation length, operation value and a reason tag, which strict parsing rejects.
		put(rlt_tlv_pkg::TAG_OP, 1'b1, 1'b0, rlt_tlv_pkg::KIND_STRICT);
		put(8'h00, 1'b0, 1'b1, rlt_tlv_pkg::KIND_STRICT);
		put(rlt_tlv_pkg::TAG_OP, 1'b1, 1'b0, rlt_tlv_pkg::KIND_STRICT);
		put(rlt_tlv_pkg::OP_LEN, 1'b0, 1'b0, rlt_tlv_pkg::KIND_STRICT);
		put(8'h00, 1'b0, 1'b1, rlt_tlv_pkg::KIND_STRICT);
		put(rlt_tlv_pkg::TAG_RSN, 1'b1, 1'b1, rlt_tlv_pkg::KIND_STRICT);
		// Truncation inside a call id, then a byte of a kind that parses nothing.
		put(rlt_tlv_pkg::TAG_CID, 1'b1, 1'b1, rlt_tlv_pkg::KIND_STRICT);
		put(rlt_tlv_pkg::TAG_SEQ, 1'b1, 1'b1, KIND_NONE_LOW);
		// No first mark after a last byte, with the kind changing on each byte.
		put(rlt_tlv_pkg::TAG_CID, 1'b0, 1'b0, rlt_tlv_pkg::KIND_LENIENT);
		put(rlt_tlv_pkg::CID_LEN_FOUR, 1'b0, 1'b0, rlt_tlv_pkg::KIND_STRICT);
		put(8'h55, 1'b0, 1'b0, KIND_NONE_HIGH);
		put(8'h0F, 1'b0, 1'b0, rlt_tlv_pkg::KIND_LENIENT);
		put(8'h00, 1'b0, 1'b1, rlt_tlv_pkg::KIND_STRICT);
		flush_words();

		for (int p = 0; p < 4; p++) begin
			quiesce();
			case (p)
				0: op_val = 8'h00;
				1: op_val = 8'hFF;
				2: op_val = 8'($urandom);
				default: op_val = rlt_tlv_pkg::EXP_OP_RESET;
			endcase
			write_exp_op(op_val);
			if (p == 1) begin
				hold_req = 1'b1;
				fast_left = 150;
			end
			target = book.bytes_taken + PHASE_ITEMS;
			while (book.bytes_taken < target) begin
				build_random_message();
				flush_words();
			end
		end

		quiesce();
		repeat (8) @(posedge clk);
		$display("Sent %0d bytes in %0d messages under %0d operation settings.",
			book.bytes_taken, sent_messages, settings_used);
		$display("Checked %0d results, including a %0d-cycle receiver hold-off; %0d mismatches.",
			book.results_checked, HOLD_CYCLES, book.errors);
		if (book.errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule

// ===== rlt_component_tlv_parser_core.f =====
+incdir+rtl
rtl/rlt_tlv_pkg.sv
rtl/rlt_tlv_byte_if.sv
rtl/rlt_tlv_result_if.sv
rtl/rlt_component_tlv_parser_core.sv
rtl/rlt_tlv_chk.sv
test/testbench.sv
